// ===== hdl/dtfc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtfc_pkg
// Shared widths, color-map constants and the tent function for the depth to
// false-color mapper.
// ----------------------------------------------------------------------------
package dtfc_pkg;

  // Field widths of the stream payloads
  localparam int DEPTH_FIELD_W = 16;
  localparam int COLOR_W       = 8;
  localparam int DIV_W         = 16;

  // Default number of depth bits in use
  localparam int DEPTH_WIDTH_DEF = 16;

  // Scale: depth * 1024 / max_depth
  localparam int SCALE_SHIFT = 10;

  // Divider steps (quotient bits) resolved per pipeline stage
  localparam int DIV_STEPS = 4;

  // Scaled value is saturated to this width; anything at or above the top
  // of the blue tent already maps to black
  localparam int SCALED_W = 11;

  localparam logic [SCALED_W-1:0] TENT_PEAK    = 11'd384;
  localparam logic [SCALED_W-1:0] CENTER_RED   = 11'd256;
  localparam logic [SCALED_W-1:0] CENTER_GREEN = 11'd512;
  localparam logic [SCALED_W-1:0] CENTER_BLUE  = 11'd768;
  localparam logic [COLOR_W-1:0]  CHANNEL_MAX  = 8'd255;
  localparam logic [DIV_W-1:0]    MAX_DEPTH_RESET = 16'd8000;

  // One color channel: 384 minus distance from center, clamped to 0..255
  function automatic logic [COLOR_W-1:0] tent(input logic [SCALED_W-1:0] scaled,
                                              input logic [SCALED_W-1:0] center);
    logic [SCALED_W-1:0] span;
    logic [SCALED_W-1:0] v;
    logic [COLOR_W-1:0]  res;
    span = (scaled >= center) ? (scaled - center) : (center - scaled);
    v    = TENT_PEAK - span;
    if (span >= TENT_PEAK) begin
      res = '0;
    end else if (v > {{(SCALED_W-COLOR_W){1'b0}}, CHANNEL_MAX}) begin
      res = CHANNEL_MAX;
    end else begin
      res = v[COLOR_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== hdl/dtfc_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtfc stream interfaces
// Valid/ready channels for depth samples in and RGBA pixels out.
// ----------------------------------------------------------------------------
interface dtfc_depth_if
  import dtfc_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [DEPTH_FIELD_W-1:0] depth;

  modport source (output valid, output depth, input ready);
  modport sink   (input valid, input depth, output ready);
endinterface

interface dtfc_pixel_if
  import dtfc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;
  logic [COLOR_W-1:0] alpha;

  modport source (output valid, output red, output green, output blue,
                  output alpha, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input alpha, output ready);
endinterface

// ===== hdl/depth_to_false_color.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_to_false_color
// Maps each depth sample to an RGBA pixel on a three-tent color scale.
// ----------------------------------------------------------------------------
// Usage:
//   sample : valid/ready sink, one depth sample per transaction.
//   pixel  : valid/ready source, one RGBA pixel per accepted sample, in order.
//   max_depth_we / max_depth_wdata : write the full-scale depth; a write of
//   zero acts as one. Write only while no sample is in flight.
// Throughput: one sample per clock while the pixel output is not stalled. The
//   scale division is a restoring divider cut into ceil((DEPTH_WIDTH+10)/4)
//   stages of up to four quotient bits; at DEPTH_WIDTH = 16 that is 7 divider
//   stages, followed by the color stage that registers the pixel.
// Stall: every stage holds its transaction while the one after it is full
//   and stalled; empty stages keep filling, so samples are still taken while
//   a finished pixel waits. Nothing is dropped or repeated.
// Reset: rst clears all stage valid bits and sets max_depth to 8000.
// ----------------------------------------------------------------------------
module depth_to_false_color
  import dtfc_pkg::*;
#(
  parameter int DEPTH_WIDTH = DEPTH_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  dtfc_depth_if.sink         sample,
  dtfc_pixel_if.source       pixel,
  input  logic               max_depth_we,
  input  logic [DIV_W-1:0]   max_depth_wdata
);

  localparam int NUM_W = DEPTH_WIDTH + SCALE_SHIFT;
  localparam int ACC_W = DIV_W + NUM_W;
  localparam int NSTG  = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;

  // One restoring division step: shift in a numerator bit, subtract if it fits
  function automatic logic [ACC_W-1:0] div_step(input logic [ACC_W-1:0] a,
                                                input logic [DIV_W-1:0] d);
    logic [DIV_W:0] t;
    logic [DIV_W:0] diff;
    t    = a[ACC_W-1:NUM_W-1];
    diff = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      return {diff[DIV_W-1:0], a[NUM_W-2:0], 1'b1};
    end else begin
      return {t[DIV_W-1:0], a[NUM_W-2:0], 1'b0};
    end
  endfunction

  logic [DIV_W-1:0] max_depth;
  logic [NSTG-1:0]  stg_vld;
  logic [ACC_W-1:0] stg_acc [NSTG];
  logic [ACC_W-1:0] stg_acc_next [NSTG];
  logic [NSTG:0]    stg_rdy;
  logic [ACC_W-1:0] acc_load;
  logic             out_vld;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;
  logic [NUM_W-1:0]   quot;
  logic [SCALED_W-1:0] scaled;

  // Hold the divisor; a zero write is stored as one
  always_ff @(posedge clk) begin
    if (rst) begin
      max_depth <= MAX_DEPTH_RESET;
    end else if (max_depth_we) begin
      max_depth <= (max_depth_wdata == '0) ? DIV_W'(1) : max_depth_wdata;
    end
  end

  // Load numerator depth * 1024 with a cleared partial remainder
  assign acc_load = {{DIV_W{1'b0}}, sample.depth[DEPTH_WIDTH-1:0], {SCALE_SHIFT{1'b0}}};

  // Stage ready: free when empty or when the next stage moves
  assign stg_rdy[NSTG] = !out_vld || pixel.ready;
  assign sample.ready  = stg_rdy[0];

  // Divider pipeline, up to four quotient bits per stage
  for (genvar k = 0; k < NSTG; k++) begin : g_div
    logic [ACC_W-1:0] acc_src;
    logic             vld_src;

    if (k == 0) begin : g_first
      assign acc_src = acc_load;
      assign vld_src = sample.valid;
    end else begin : g_rest
      assign acc_src = stg_acc[k-1];
      assign vld_src = stg_vld[k-1];
    end

    assign stg_rdy[k] = !stg_vld[k] || stg_rdy[k+1];

    always_comb begin
      stg_acc_next[k] = acc_src;
      for (int j = 0; j < DIV_STEPS; j++) begin
        if (k * DIV_STEPS + j < NUM_W) begin
          stg_acc_next[k] = div_step(stg_acc_next[k], max_depth);
        end
      end
    end

    // Advance valid bit and data together
    always_ff @(posedge clk) begin
      if (rst) begin
        stg_vld[k] <= 1'b0;
      end else if (stg_rdy[k]) begin
        stg_vld[k] <= vld_src;
      end
    end

    always_ff @(posedge clk) begin
      if (stg_rdy[k] && vld_src) begin
        stg_acc[k] <= stg_acc_next[k];
      end
    end
  end

  // Saturate the quotient; values past the blue tent are all black anyway
  assign quot   = stg_acc[NSTG-1][NUM_W-1:0];
  assign scaled = (|quot[NUM_W-1:SCALED_W]) ? {SCALED_W{1'b1}} : quot[SCALED_W-1:0];

  // Color stage and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (stg_rdy[NSTG]) begin
      out_vld <= stg_vld[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (stg_rdy[NSTG] && stg_vld[NSTG-1]) begin
      red   <= tent(scaled, CENTER_RED);
      green <= tent(scaled, CENTER_GREEN);
      blue  <= tent(scaled, CENTER_BLUE);
    end
  end

  assign pixel.valid = out_vld;
  assign pixel.red   = red;
  assign pixel.green = green;
  assign pixel.blue  = blue;
  assign pixel.alpha = CHANNEL_MAX;

  // Divisor never reaches zero
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    max_depth != '0)
    else $error("max_depth register holds zero");

  // An accepted transaction occupies the first divider stage next cycle
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    sample.valid && sample.ready |=> stg_vld[0])
    else $error("accepted sample not captured in first stage");

  // Red and blue both lit only in the middle, where green is saturated
  a_tent_overlap: assert property (@(posedge clk) disable iff (rst)
    pixel.valid && pixel.red != '0 && pixel.blue != '0 |-> pixel.green == CHANNEL_MAX)
    else $error("red and blue overlap without full green");

endmodule
